// ===== rtl/gost_block_cipher_core_macros.svh =====
// Assertion macros shared by the checker of the GOST block cipher core.
// All macros sample on clk and are disabled while rst_n is low.
`ifndef GOST_BLOCK_CIPHER_CORE_MACROS_SVH
`define GOST_BLOCK_CIPHER_CORE_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define GBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The expression must never be true at a clock edge.
`define GBC_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/gbc_pkg.sv =====
// Shared types, constants and functions of the GOST block cipher core.
// Used by gbc_round_cell, gost_block_cipher_core and gbc_checker; no dependencies.
`default_nettype none

package gbc_pkg;

  localparam int NUM_ROUNDS  = 32;
  localparam int IMIT_ROUNDS = 16;
  localparam int ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int NUM_KEYS    = 8;
  localparam int KEY_IDX_W   = $clog2(NUM_KEYS);

  localparam int BLOCK_W = 64;
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W  = 2;

  // Operating modes.
  localparam logic [MODE_W-1:0] MODE_ENCRYPT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECRYPT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IMIT    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PAIR_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd4;

  // Per-round control handed to each cell.
  typedef struct packed {
    logic active;  // the round does work; otherwise the block passes through
    logic last;    // final round: fold F into N2 and keep the halves in place
  } cell_ctl_t;

  // Substitution table; row p serves nibble p counted from the LSB.
  localparam logic [3:0] SBOX [0:7][0:15] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd1,  4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  function automatic logic [WORD_W-1:0] sbox_sub(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int p = 0; p < 8; p++) begin
      res[4*p +: 4] = SBOX[p][x[4*p +: 4]];
    end
    return res;
  endfunction

  // Key schedule: which key word a given round uses in a given mode.
  function automatic logic [KEY_IDX_W-1:0] key_index(input logic [MODE_W-1:0] mode,
                                                      input logic [ROUND_W-1:0] rnd);
    logic [KEY_IDX_W-1:0] idx;
    unique case (mode)
      MODE_ENCRYPT: begin
        idx = (rnd < ROUND_W'(24)) ? rnd[KEY_IDX_W-1:0] : ~rnd[KEY_IDX_W-1:0];
      end
      MODE_DECRYPT: begin
        idx = (rnd < ROUND_W'(8)) ? rnd[KEY_IDX_W-1:0] : ~rnd[KEY_IDX_W-1:0];
      end
      default: begin
        idx = rnd[KEY_IDX_W-1:0];
      end
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gbc_round_cell.sv =====
// One round cell of the GOST block cipher pipeline: add key, substitute,
// rotate and mix, then register the block. Depends on gbc_pkg.
`default_nettype none

module gbc_round_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [gbc_pkg::BLOCK_W-1:0]   in_block,
  input  wire logic [gbc_pkg::WORD_W-1:0]    key_word,
  input  wire gbc_pkg::cell_ctl_t            ctl,
  output logic                               out_valid,
  output logic [gbc_pkg::BLOCK_W-1:0]        out_block
);

  logic                            valid_r;
  logic [gbc_pkg::BLOCK_W-1:0]     block_r;
  logic [gbc_pkg::BLOCK_W-1:0]     block_nxt;
  logic [gbc_pkg::WORD_W-1:0]      n1;
  logic [gbc_pkg::WORD_W-1:0]      n2;
  logic [gbc_pkg::WORD_W-1:0]      sub;
  logic [gbc_pkg::WORD_W-1:0]      f;

  assign n1  = in_block[gbc_pkg::WORD_W-1:0];
  assign n2  = in_block[gbc_pkg::BLOCK_W-1:gbc_pkg::WORD_W];
  assign sub = gbc_pkg::sbox_sub(n1 + key_word);
  assign f   = {sub[20:0], sub[31:21]};

  always_comb begin
    if (!ctl.active) begin
      block_nxt = in_block;
    end else if (ctl.last) begin
      block_nxt = {n2 ^ f, n1};
    end else begin
      block_nxt = {n1, n2 ^ f};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    block_r <= block_nxt;
  end

  assign out_valid = valid_r;
  assign out_block = block_r;

endmodule

`default_nettype wire

// ===== rtl/gost_block_cipher_core.sv =====
// Top level of the GOST block cipher core: configuration registers, key
// schedule and a chain of gbc_round_cell stages. Depends on gbc_pkg.
//
// Usage:
//   Input: a 64-bit block on in_block_in is transferred at each rising edge
//   where start is high and busy is low. busy is always low: the core takes
//   a new block in every cycle.
//   Output: out_valid strobes for one cycle with out_block_out; the block
//   leaves the chain after its last round cell, in every mode. The receiver
//   cannot stall the core and must take each result when it is shown.
//   Throughput is one block per cycle; each block passes through the 32 round
//   cells, one registered round each. In imitation mode the last 16 cells
//   pass the block through unchanged.
//   Configuration: cfg_we writes cfg_data into register cfg_index (key pairs
//   0 to 3, then the mode). Write only while no block is in the chain.
//   Mode value three behaves as imitation; indexes past the mode are ignored.
//   Reset: synchronous, active low; clears the configuration and valid flags,
//   dropping every block in flight, so out_valid is low in the cycle after reset.
`default_nettype none

module gost_block_cipher_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [gbc_pkg::BLOCK_W-1:0]       in_block_in,
  output logic                                   out_valid,
  output logic [gbc_pkg::BLOCK_W-1:0]            out_block_out,
  input  wire logic                              cfg_we,
  input  wire logic [gbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gbc_pkg::CFG_W-1:0]         cfg_data
);

  logic [gbc_pkg::BLOCK_W-1:0] key_pair_0_r;
  logic [gbc_pkg::BLOCK_W-1:0] key_pair_1_r;
  logic [gbc_pkg::BLOCK_W-1:0] key_pair_2_r;
  logic [gbc_pkg::BLOCK_W-1:0] key_pair_3_r;
  logic [gbc_pkg::MODE_W-1:0]  cipher_mode_r;
  logic [gbc_pkg::MODE_W-1:0]  mode_eff;
  logic                        not_imit;

  logic [gbc_pkg::WORD_W-1:0]  key_w [gbc_pkg::NUM_KEYS];
  logic                        stage_valid [gbc_pkg::NUM_ROUNDS+1];
  logic [gbc_pkg::BLOCK_W-1:0] stage_block [gbc_pkg::NUM_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pair_0_r  <= '0;
      key_pair_1_r  <= '0;
      key_pair_2_r  <= '0;
      key_pair_3_r  <= '0;
      cipher_mode_r <= gbc_pkg::MODE_ENCRYPT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbc_pkg::REG_KEY_PAIR_0:  key_pair_0_r  <= cfg_data;
        gbc_pkg::REG_KEY_PAIR_1:  key_pair_1_r  <= cfg_data;
        gbc_pkg::REG_KEY_PAIR_2:  key_pair_2_r  <= cfg_data;
        gbc_pkg::REG_KEY_PAIR_3:  key_pair_3_r  <= cfg_data;
        gbc_pkg::REG_CIPHER_MODE: cipher_mode_r <= cfg_data[gbc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // The unused mode code falls back to imitation.
  assign mode_eff = (cipher_mode_r == gbc_pkg::MODE_ENCRYPT ||
                     cipher_mode_r == gbc_pkg::MODE_DECRYPT) ?
                    cipher_mode_r : gbc_pkg::MODE_IMIT;
  assign not_imit = (mode_eff != gbc_pkg::MODE_IMIT);

  // Even key words sit in the upper half of each pair.
  assign key_w[0] = key_pair_0_r[63:32];
  assign key_w[1] = key_pair_0_r[31:0];
  assign key_w[2] = key_pair_1_r[63:32];
  assign key_w[3] = key_pair_1_r[31:0];
  assign key_w[4] = key_pair_2_r[63:32];
  assign key_w[5] = key_pair_2_r[31:0];
  assign key_w[6] = key_pair_3_r[63:32];
  assign key_w[7] = key_pair_3_r[31:0];

  assign busy           = 1'b0;
  assign stage_valid[0] = start && !busy;
  assign stage_block[0] = in_block_in;

  for (genvar r = 0; r < gbc_pkg::NUM_ROUNDS; r++) begin : g_round
    localparam logic [gbc_pkg::ROUND_W-1:0] RND = gbc_pkg::ROUND_W'(r);
    logic [gbc_pkg::KEY_IDX_W-1:0] kidx;
    gbc_pkg::cell_ctl_t            ctl;

    assign kidx       = gbc_pkg::key_index(mode_eff, RND);
    assign ctl.active = not_imit || (RND < gbc_pkg::ROUND_W'(gbc_pkg::IMIT_ROUNDS));
    assign ctl.last   = not_imit && (RND == gbc_pkg::ROUND_W'(gbc_pkg::NUM_ROUNDS - 1));

    gbc_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_valid[r]),
      .in_block  (stage_block[r]),
      .key_word  (key_w[kidx]),
      .ctl       (ctl),
      .out_valid (stage_valid[r+1]),
      .out_block (stage_block[r+1])
    );
  end

  assign out_valid     = stage_valid[gbc_pkg::NUM_ROUNDS];
  assign out_block_out = stage_block[gbc_pkg::NUM_ROUNDS];

endmodule

`default_nettype wire

// ===== rtl/gbc_checker.sv =====
// Port-level checker for gost_block_cipher_core, attached by bind.
// Depends on gbc_pkg and gost_block_cipher_core_macros.svh.
`default_nettype none
`include "gost_block_cipher_core_macros.svh"

module gbc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // Every result comes from a transfer exactly one pipeline length earlier.
  `GBC_ASSERT_IMPL(a_result_has_source, out_valid, $past(start && !busy, gbc_pkg::NUM_ROUNDS))

  // Reset drops all blocks in flight.
  `GBC_ASSERT_IMPL(a_reset_flushes, $past(!rst_n), !out_valid)

  // The chain takes a block in every cycle.
  `GBC_ASSERT_NEVER(a_never_busy, busy)

endmodule

bind gost_block_cipher_core gbc_checker u_gbc_checker (.*);

`default_nettype wire
